@@ rtl/tsq_pkg.sv @@
// shared types, constants and command codes of the thread scheduler
package tsq_pkg;

  localparam int THREAD_SLOTS = 256;
  localparam int SLOT_W       = $clog2(THREAD_SLOTS);
  localparam int TID_W        = $clog2(THREAD_SLOTS + 2);
  localparam int CNT_W        = $clog2(THREAD_SLOTS + 1);
  localparam int LINK_DEPTH   = THREAD_SLOTS + 1;
  localparam int TIME_W       = 64;
  localparam int CODE_W       = 32;
  localparam int KIND_W       = 3;
  localparam int TARGET_W     = 9;
  localparam int STATUS_W     = 2;

  typedef logic [TID_W-1:0] tid_t;

  localparam tid_t IDLE_TID = TID_W'(THREAD_SLOTS);
  localparam tid_t NIL_TID  = TID_W'(THREAD_SLOTS + 1);

  typedef enum logic [KIND_W-1:0] {
    K_TICK   = 3'd0,
    K_CREATE = 3'd1,
    K_YIELD  = 3'd2,
    K_SLEEP  = 3'd3,
    K_EXIT   = 3'd4,
    K_JOIN   = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_SLOT    = 2'd1,
    ST_BAD_TARGET = 2'd2,
    ST_NOT_ZERO   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_TICK_START,
    OP_TICK_RD,
    OP_TICK_EV,
    OP_PUSH_CUR,
    OP_POP_RD,
    OP_POP_FIN,
    OP_SLEEP,
    OP_EXIT,
    OP_JOIN,
    OP_BAD_TARGET,
    OP_NOT_ZERO,
    OP_SCAN,
    OP_CREATE,
    OP_NO_SLOT
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_TICK_RD,
    S_TICK_EV,
    S_YIELD_CHK,
    S_PUSH,
    S_POP_RD,
    S_POP_FIN,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t  op;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  sleep_empty;
    logic  ready_empty;
    logic  cur_is_slot;
    logic  cur_is_zero;
    logic  target_ok;
    logic  preempt;
    logic  tick_last;
    logic  scan_end;
    logic  scan_hit;
  } dp_stat_t;

endpackage

@@ rtl/thread_scheduler_queues_top.sv @@
// top level of the thread scheduler with ready, sleep and join queues
//
//  channel | direction | handshake            | carries
//  --------+-----------+----------------------+-------------------------------------
//  in_     | input     | in_valid / in_ready  | one event item (kind, time, ...)
//  out_    | output    | out_valid / out_ready| one result item per event
//  cfg_    | input     | cfg_wr_en            | preempt enable bit, no wait
//
// one event at a time: a new item is taken only once the last result is loaded
// yield pushes the current thread and pops the ready head; sleep, exit and join pop it;
// ignored, rejected or unknown events go straight to the output; tick walks the sleep
// queue with one link/wakeup read per sleeper, then may yield; create looks for the lowest
// free slot, to the end when the table is full: the slot table is scanned one entry a cycle
// synchronous active-low reset; no clearing pass, link and wakeup memories are
// only read for threads that sit in a queue
// the result sits in an output register, so a stalled out_ready only holds the
// block once the next result is ready to load
module thread_scheduler_queues_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_wr_en,
  input  logic                               cfg_wr_data,
  // event items
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tsq_pkg::KIND_W-1:0]         in_kind,
  input  logic [tsq_pkg::TIME_W-1:0]         in_current_time,
  input  logic [tsq_pkg::TIME_W-1:0]         in_sleep_period,
  input  logic signed [tsq_pkg::CODE_W-1:0]  in_exit_code,
  input  logic [tsq_pkg::TARGET_W-1:0]       in_target_tid,
  // result items
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tsq_pkg::TID_W-1:0]          out_running_tid,
  output logic [tsq_pkg::STATUS_W-1:0]       out_status,
  output logic [tsq_pkg::SLOT_W-1:0]         out_created_tid,
  output logic                               out_joiner_woken,
  output logic [tsq_pkg::SLOT_W-1:0]         out_joiner_tid,
  output logic signed [tsq_pkg::CODE_W-1:0]  out_delivered_code,
  output logic [tsq_pkg::CNT_W-1:0]          out_woken_count
);
  import tsq_pkg::*;

  // command and status between controller and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: dispatch on event kind, walk the sleep queue, scan for a free
  // slot, pop the ready head, then load the output register
  tsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // queue heads and tails, slot table, join waiter, link and wakeup memories
  tsq_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_kind            (in_kind),
    .in_current_time    (in_current_time),
    .in_sleep_period    (in_sleep_period),
    .in_exit_code       (in_exit_code),
    .in_target_tid      (in_target_tid),
    .out_running_tid    (out_running_tid),
    .out_status         (out_status),
    .out_created_tid    (out_created_tid),
    .out_joiner_woken   (out_joiner_woken),
    .out_joiner_tid     (out_joiner_tid),
    .out_delivered_code (out_delivered_code),
    .out_woken_count    (out_woken_count)
  );

endmodule

@@ rtl/tsq_ram.sv @@
// generic single write port ram with registered read
module tsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tsq_dp.sv @@
// scheduler datapath: queues, slot table, link and wakeup memories
module tsq_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tsq_pkg::dp_cmd_t                 cmd,
  output tsq_pkg::dp_stat_t                stat,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_wr_data,
  input  logic [tsq_pkg::KIND_W-1:0]       in_kind,
  input  logic [tsq_pkg::TIME_W-1:0]       in_current_time,
  input  logic [tsq_pkg::TIME_W-1:0]       in_sleep_period,
  input  logic signed [tsq_pkg::CODE_W-1:0] in_exit_code,
  input  logic [tsq_pkg::TARGET_W-1:0]     in_target_tid,
  output logic [tsq_pkg::TID_W-1:0]        out_running_tid,
  output logic [tsq_pkg::STATUS_W-1:0]     out_status,
  output logic [tsq_pkg::SLOT_W-1:0]       out_created_tid,
  output logic                             out_joiner_woken,
  output logic [tsq_pkg::SLOT_W-1:0]       out_joiner_tid,
  output logic signed [tsq_pkg::CODE_W-1:0] out_delivered_code,
  output logic [tsq_pkg::CNT_W-1:0]        out_woken_count
);
  import tsq_pkg::*;

  // control state
  tid_t ready_head_r, ready_head_nxt, ready_tail_r, ready_tail_nxt;
  tid_t sleep_head_r, sleep_head_nxt, sleep_tail_r, sleep_tail_nxt;
  tid_t cur_r, cur_nxt;
  logic [THREAD_SLOTS-1:0] slot_used_r, slot_used_nxt;
  logic jw_valid_r, jw_valid_nxt;
  logic [SLOT_W-1:0] jw_target_r, jw_target_nxt;
  logic preempt_r;

  // per-item working registers
  kind_t kind_r, kind_nxt;
  logic [TIME_W-1:0] now_r, now_nxt, period_r, period_nxt;
  logic signed [CODE_W-1:0] code_r, code_nxt;
  logic [TARGET_W-1:0] target_r, target_nxt;
  tid_t n_r, n_nxt, stop_r, stop_nxt, kh_r, kh_nxt, kt_r, kt_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, scan_r, scan_nxt;
  status_t status_r, status_nxt;
  logic [SLOT_W-1:0] created_r, created_nxt;
  logic woken_r, woken_nxt;
  logic signed [CODE_W-1:0] dcode_r, dcode_nxt;

  // memories
  logic link_we;
  tid_t link_wa, link_wd, link_ra, link_rdata;
  logic wake_we;
  logic [SLOT_W-1:0] wake_wa, wake_ra;
  logic [TIME_W-1:0] wake_wd, wake_rdata;

  tsq_ram #(.WIDTH(TID_W), .DEPTH(LINK_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_wa),
    .wdata (link_wd),
    .raddr (link_ra),
    .rdata (link_rdata)
  );

  tsq_ram #(.WIDTH(TIME_W), .DEPTH(THREAD_SLOTS)) u_wake_ram (
    .clk   (clk),
    .we    (wake_we),
    .waddr (wake_wa),
    .wdata (wake_wd),
    .raddr (wake_ra),
    .rdata (wake_rdata)
  );

  assign link_ra = (cmd.op == OP_TICK_RD) ? n_r : ready_head_r;
  assign wake_ra = n_r[SLOT_W-1:0];
  assign wake_wa = cur_r[SLOT_W-1:0];
  assign wake_wd = now_r + period_r;

  always_comb begin
    stat.kind        = kind_r;
    stat.sleep_empty = (sleep_head_r == NIL_TID);
    stat.ready_empty = (ready_head_r == NIL_TID);
    stat.cur_is_slot = (cur_r < IDLE_TID);
    stat.cur_is_zero = (cur_r == '0);
    stat.target_ok   = (target_r < TARGET_W'(THREAD_SLOTS)) &&
                       slot_used_r[target_r[SLOT_W-1:0]];
    stat.preempt     = preempt_r;
    stat.tick_last   = (n_r == stop_r);
    stat.scan_end    = (scan_r == CNT_W'(THREAD_SLOTS));
    stat.scan_hit    = !slot_used_r[scan_r[SLOT_W-1:0]];
  end

  always_comb begin
    ready_head_nxt = ready_head_r;
    ready_tail_nxt = ready_tail_r;
    sleep_head_nxt = sleep_head_r;
    sleep_tail_nxt = sleep_tail_r;
    cur_nxt        = cur_r;
    slot_used_nxt  = slot_used_r;
    jw_valid_nxt   = jw_valid_r;
    jw_target_nxt  = jw_target_r;
    kind_nxt       = kind_r;
    now_nxt        = now_r;
    period_nxt     = period_r;
    code_nxt       = code_r;
    target_nxt     = target_r;
    n_nxt          = n_r;
    stop_nxt       = stop_r;
    kh_nxt         = kh_r;
    kt_nxt         = kt_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    status_nxt     = status_r;
    created_nxt    = created_r;
    woken_nxt      = woken_r;
    dcode_nxt      = dcode_r;
    link_we        = 1'b0;
    link_wa        = ready_tail_r;
    link_wd        = cur_r;
    wake_we        = 1'b0;

    case (cmd.op)
      OP_LOAD: begin
        kind_nxt    = kind_t'(in_kind);
        now_nxt     = in_current_time;
        period_nxt  = in_sleep_period;
        code_nxt    = in_exit_code;
        target_nxt  = in_target_tid;
        status_nxt  = ST_OK;
        created_nxt = '0;
        woken_nxt   = 1'b0;
        dcode_nxt   = '0;
        count_nxt   = '0;
        scan_nxt    = '0;
      end
      OP_TICK_START: begin
        n_nxt    = sleep_head_r;
        stop_nxt = sleep_tail_r;
        kh_nxt   = NIL_TID;
        kt_nxt   = NIL_TID;
      end
      OP_TICK_EV: begin
        if (wake_rdata < now_r) begin
          // expired sleeper goes to ready tail
          if (ready_head_r == NIL_TID) begin
            ready_head_nxt = n_r;
          end else begin
            link_we = 1'b1;
            link_wa = ready_tail_r;
            link_wd = n_r;
          end
          ready_tail_nxt = n_r;
          count_nxt      = count_r + 1'b1;
        end else begin
          // still asleep, rebuilt keep list
          if (kh_r == NIL_TID) begin
            kh_nxt = n_r;
          end else begin
            link_we = 1'b1;
            link_wa = kt_r;
            link_wd = n_r;
          end
          kt_nxt = n_r;
        end
        n_nxt = link_rdata;
        if (n_r == stop_r) begin
          sleep_head_nxt = kh_nxt;
          sleep_tail_nxt = kt_nxt;
        end
      end
      OP_PUSH_CUR: begin
        if (ready_head_r == NIL_TID) begin
          ready_head_nxt = cur_r;
        end else begin
          link_we = 1'b1;
          link_wa = ready_tail_r;
          link_wd = cur_r;
        end
        ready_tail_nxt = cur_r;
      end
      OP_POP_FIN: begin
        cur_nxt = ready_head_r;
        if (ready_head_r == ready_tail_r) begin
          ready_head_nxt = NIL_TID;
          ready_tail_nxt = NIL_TID;
        end else begin
          ready_head_nxt = link_rdata;
        end
      end
      OP_SLEEP: begin
        wake_we = 1'b1;
        if (sleep_head_r == NIL_TID) begin
          sleep_head_nxt = cur_r;
        end else begin
          link_we = 1'b1;
          link_wa = sleep_tail_r;
          link_wd = cur_r;
        end
        sleep_tail_nxt = cur_r;
      end
      OP_EXIT: begin
        slot_used_nxt[cur_r[SLOT_W-1:0]] = 1'b0;
        // only thread 0 ever joins, so one waiter at most
        if (jw_valid_r && (jw_target_r == cur_r[SLOT_W-1:0])) begin
          jw_valid_nxt = 1'b0;
          woken_nxt    = 1'b1;
          dcode_nxt    = code_r;
          if (ready_head_r == NIL_TID) begin
            ready_head_nxt = '0;
          end else begin
            link_we = 1'b1;
            link_wa = ready_tail_r;
            link_wd = '0;
          end
          ready_tail_nxt = '0;
        end
      end
      OP_JOIN: begin
        jw_valid_nxt  = 1'b1;
        jw_target_nxt = target_r[SLOT_W-1:0];
      end
      OP_BAD_TARGET: status_nxt = ST_BAD_TARGET;
      OP_NOT_ZERO:   status_nxt = ST_NOT_ZERO;
      OP_SCAN:       scan_nxt = scan_r + 1'b1;
      OP_CREATE: begin
        slot_used_nxt[scan_r[SLOT_W-1:0]] = 1'b1;
        created_nxt = scan_r[SLOT_W-1:0];
        if (ready_head_r == NIL_TID) begin
          ready_head_nxt = TID_W'(scan_r);
        end else begin
          link_we = 1'b1;
          link_wa = ready_tail_r;
          link_wd = TID_W'(scan_r);
        end
        ready_tail_nxt = TID_W'(scan_r);
      end
      OP_NO_SLOT: status_nxt = ST_NO_SLOT;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_head_r <= IDLE_TID;
      ready_tail_r <= IDLE_TID;
      sleep_head_r <= NIL_TID;
      sleep_tail_r <= NIL_TID;
      cur_r        <= '0;
      slot_used_r  <= THREAD_SLOTS'(1);
      jw_valid_r   <= 1'b0;
      preempt_r    <= 1'b1;
    end else begin
      ready_head_r <= ready_head_nxt;
      ready_tail_r <= ready_tail_nxt;
      sleep_head_r <= sleep_head_nxt;
      sleep_tail_r <= sleep_tail_nxt;
      cur_r        <= cur_nxt;
      slot_used_r  <= slot_used_nxt;
      jw_valid_r   <= jw_valid_nxt;
      if (cfg_wr_en) begin
        preempt_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    jw_target_r <= jw_target_nxt;
    kind_r      <= kind_nxt;
    now_r       <= now_nxt;
    period_r    <= period_nxt;
    code_r      <= code_nxt;
    target_r    <= target_nxt;
    n_r         <= n_nxt;
    stop_r      <= stop_nxt;
    kh_r        <= kh_nxt;
    kt_r        <= kt_nxt;
    count_r     <= count_nxt;
    scan_r      <= scan_nxt;
    status_r    <= status_nxt;
    created_r   <= created_nxt;
    woken_r     <= woken_nxt;
    dcode_r     <= dcode_nxt;
    if (cmd.out_load) begin
      out_running_tid    <= cur_r;
      out_status         <= status_r;
      out_created_tid    <= created_r;
      out_joiner_woken   <= woken_r;
      out_delivered_code <= dcode_r;
      out_woken_count    <= count_r;
    end
  end

  // the only thread that can join is thread 0
  assign out_joiner_tid = '0;

endmodule

@@ rtl/tsq_ctrl.sv @@
// scheduler controller state machine
module tsq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tsq_pkg::dp_stat_t  stat,
  output tsq_pkg::dp_cmd_t   cmd
);
  import tsq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    in_ready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_DONE;
        case (stat.kind)
          K_TICK: begin
            if (stat.sleep_empty) begin
              state_nxt = S_YIELD_CHK;
            end else begin
              cmd.op    = OP_TICK_START;
              state_nxt = S_TICK_RD;
            end
          end
          K_CREATE: state_nxt = S_SCAN;
          K_YIELD: begin
            if (!stat.ready_empty) begin
              state_nxt = S_PUSH;
            end
          end
          K_SLEEP: begin
            if (stat.cur_is_slot) begin
              cmd.op    = OP_SLEEP;
              state_nxt = S_POP_RD;
            end
          end
          K_EXIT: begin
            if (stat.cur_is_slot) begin
              cmd.op    = OP_EXIT;
              state_nxt = S_POP_RD;
            end
          end
          K_JOIN: begin
            if (!stat.cur_is_zero) begin
              cmd.op = OP_NOT_ZERO;
            end else if (!stat.target_ok) begin
              cmd.op = OP_BAD_TARGET;
            end else begin
              cmd.op    = OP_JOIN;
              state_nxt = S_POP_RD;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_TICK_RD: begin
        cmd.op    = OP_TICK_RD;
        state_nxt = S_TICK_EV;
      end
      S_TICK_EV: begin
        cmd.op    = OP_TICK_EV;
        state_nxt = stat.tick_last ? S_YIELD_CHK : S_TICK_RD;
      end
      S_YIELD_CHK: begin
        state_nxt = (stat.preempt && !stat.ready_empty) ? S_PUSH : S_DONE;
      end
      S_PUSH: begin
        cmd.op    = OP_PUSH_CUR;
        state_nxt = S_POP_RD;
      end
      S_POP_RD: begin
        cmd.op    = OP_POP_RD;
        state_nxt = S_POP_FIN;
      end
      S_POP_FIN: begin
        cmd.op    = OP_POP_FIN;
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          cmd.op    = OP_NO_SLOT;
          state_nxt = S_DONE;
        end else if (stat.scan_hit) begin
          cmd.op    = OP_CREATE;
          state_nxt = S_DONE;
        end else begin
          cmd.op = OP_SCAN;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
